FILE: sv/lri_pkg.sv
`default_nettype none
package lri_pkg;
  localparam int MaxLen = 256;
  localparam int ElemBits = 16;
  localparam int AddrBits = $clog2(MaxLen);
  localparam int CntBits = $clog2(MaxLen + 1);
  localparam int QDepth = 2;

  typedef struct packed {
    logic [15:0] element_value;
    logic        last_element;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] rotation_start;
    logic       overflowed;
  } out_beat_t;

  typedef struct packed {
    logic [CntBits-1:0] len;
    logic               ovf;
  } job_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_DONE
  } search_state_e;
endpackage
`default_nettype wire

FILE: sv/lri_front.sv
`default_nettype none
module lri_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire lri_pkg::in_beat_t           in_i,
  input  wire logic                        accept_i,
  output logic                             wr_en_o,
  output logic [lri_pkg::AddrBits-1:0]     wr_addr_o,
  output logic [lri_pkg::ElemBits-1:0]     wr_data_o,
  output logic                             job_valid_o,
  output lri_pkg::job_t                    job_o
);
  import lri_pkg::*;

  logic [CntBits-1:0] count_q, count_d;
  logic               ovf_q, ovf_d;
  logic               room;

  assign room      = count_q < CntBits'(MaxLen);
  assign wr_en_o   = accept_i && room;
  assign wr_addr_o = count_q[AddrBits-1:0];
  assign wr_data_o = in_i.element_value[ElemBits-1:0];

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    job_valid_o = 1'b0;
    job_o.len = count_q + CntBits'(room);
    job_o.ovf = ovf_q || !room;
    if (accept_i) begin
      if (room) count_d = count_q + 1'b1;
      else ovf_d = 1'b1;
      if (in_i.last_element) begin
        job_valid_o = 1'b1;
        count_d = '0;
        ovf_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end
endmodule
`default_nettype wire

FILE: sv/lri_queue.sv
`default_nettype none
module lri_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire lri_pkg::job_t push_data_i,
  input  wire logic          pop_i,
  output logic               empty_o,
  output logic               full_o,
  output lri_pkg::job_t      head_o
);
  import lri_pkg::*;

  job_t         mem_q [QDepth];
  logic         wp_q, rp_q;
  logic [1:0]   cnt_q;

  assign empty_o = cnt_q == 2'd0;
  assign full_o  = cnt_q == 2'(QDepth);
  assign head_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

`ifndef ASSERT_OFF
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !pop_i |-> !push_i) else $error("queue overrun");
  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("queue underrun");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(QDepth)) else $error("queue count out of range");
`endif
endmodule
`default_nettype wire

FILE: sv/lri_search.sv
`default_nettype none
module lri_search (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        job_valid_i,
  input  wire lri_pkg::job_t               job_i,
  output logic                             pop_o,
  output logic                             busy_o,
  output logic [lri_pkg::AddrBits-1:0]     rd_a_addr_o,
  output logic [lri_pkg::AddrBits-1:0]     rd_b_addr_o,
  output logic                             rd_en_o,
  input  wire logic [lri_pkg::ElemBits-1:0] rd_a_i,
  input  wire logic [lri_pkg::ElemBits-1:0] rd_b_i,
  output logic                             res_valid_o,
  output lri_pkg::out_beat_t               res_o
);
  import lri_pkg::*;

  search_state_e state_q, state_d;
  logic [CntBits:0]   i_q, i_d, j_q, j_d;
  logic [CntBits-1:0] k_q, k_d, len_q, len_d;
  logic               ovf_q, ovf_d;
  logic [CntBits:0]   ik, jk, ia, ja, ljob;
  logic [CntBits:0]   ni, nj;

  assign ljob = {1'b0, len_q};
  assign ik = i_q + (CntBits+1)'(k_q);
  assign jk = j_q + (CntBits+1)'(k_q);
  assign ia = (ik >= ljob) ? ik - ljob : ik;
  assign ja = (jk >= ljob) ? jk - ljob : jk;
  assign rd_a_addr_o = ia[AddrBits-1:0];
  assign rd_b_addr_o = ja[AddrBits-1:0];
  assign busy_o = state_q != S_IDLE;

  always_comb begin
    state_d = state_q;
    i_d = i_q; j_d = j_q; k_d = k_q; len_d = len_q; ovf_d = ovf_q;
    pop_o = 1'b0;
    rd_en_o = 1'b0;
    res_valid_o = 1'b0;
    ni = ik + 1'b1;
    nj = jk + 1'b1;
    res_o.rotation_start = (i_q < j_q) ? i_q[7:0] : j_q[7:0];
    res_o.overflowed = ovf_q;
    unique case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          pop_o = 1'b1;
          len_d = job_i.len; ovf_d = job_i.ovf;
          i_d = '0; j_d = (CntBits+1)'(1); k_d = '0;
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (i_q >= ljob || j_q >= ljob || k_q >= len_q) state_d = S_DONE;
        else begin
          rd_en_o = 1'b1;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        state_d = S_READ;
        if (rd_a_i == rd_b_i) k_d = k_q + 1'b1;
        else begin
          k_d = '0;
          if (rd_a_i > rd_b_i) begin
            i_d = ni;
            if (ni == j_q) j_d = j_q + 1'b1;
          end else begin
            j_d = nj;
            if (nj == i_q) j_d = nj + 1'b1;
          end
        end
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; j_q <= j_d; k_q <= k_d; len_q <= len_d; ovf_q <= ovf_d;
  end

`ifndef ASSERT_OFF
  a_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CMP |-> i_q != j_q) else $error("candidates met");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == S_IDLE) else $error("pop while searching");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> state_q == S_IDLE) else $error("result not single");
`endif
endmodule
`default_nettype wire

FILE: sv/least_rotation_index.sv
// Channel  | Handshake          | Payload
// input    | start_i, busy_o    | in_i (in_beat_t)
// result   | done_o strobe      | res_o (out_beat_t)
// An element beat is accepted when start_i && !busy_o.
// A search takes up to about 3*N compares.
// The compare rate is set by the two-port element memory and its read register.
// busy_o is high from the last beat of a sequence until its result strobe.
// The result cannot be stalled.
// Reset clears the counters, queue and search state; the memory is not cleared.
`default_nettype none
module least_rotation_index (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire lri_pkg::in_beat_t  in_i,
  output logic                    done_o,
  output lri_pkg::out_beat_t      res_o
);
  import lri_pkg::*;

  logic [ElemBits-1:0] mem_q [MaxLen];
  logic [ElemBits-1:0] rd_a_q, rd_b_q;
  logic                accept, wr_en, job_push, q_empty, q_full, pop, rd_en, s_busy;
  logic [AddrBits-1:0] wr_addr, ra, rb;
  logic [ElemBits-1:0] wr_data;
  job_t                job, head;

  // A new sequence cannot overwrite memory while a search still reads it.
  assign busy_o = q_full || (s_busy && !q_empty) || (s_busy || !q_empty);
  assign accept = start_i && !busy_o;

  lri_front u_front (
    .clk_i, .rst_ni, .in_i, .accept_i(accept),
    .wr_en_o(wr_en), .wr_addr_o(wr_addr), .wr_data_o(wr_data),
    .job_valid_o(job_push), .job_o(job)
  );

  lri_queue u_queue (
    .clk_i, .rst_ni, .push_i(job_push), .push_data_i(job), .pop_i(pop),
    .empty_o(q_empty), .full_o(q_full), .head_o(head)
  );

  lri_search u_search (
    .clk_i, .rst_ni, .job_valid_i(!q_empty), .job_i(head), .pop_o(pop),
    .busy_o(s_busy), .rd_a_addr_o(ra), .rd_b_addr_o(rb), .rd_en_o(rd_en),
    .rd_a_i(rd_a_q), .rd_b_i(rd_b_q), .res_valid_o(done_o), .res_o
  );

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) begin
      rd_a_q <= mem_q[ra];
      rd_b_q <= mem_q[rb];
    end
  end

`ifndef ASSERT_OFF
  a_no_write_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_busy |-> !wr_en) else $error("memory written during search");
  a_busy_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !accept) else $error("beat taken while busy");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push |-> !q_full) else $error("job lost");
`endif
endmodule
`default_nettype wire

FILE: sim/least_rotation_index_test.sv
`default_nettype none
module least_rotation_index_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lri_pkg::*;

  class rotation_board;
    logic [15:0] seq_elems[$];
    bit          seq_ovf;
    out_beat_t   pending[$];
    int          errors;

    function automatic int least_start(int len);
      int i, j, k;
      logic [15:0] a, b;
      i = 0;
      j = 1;
      k = 0;
      while (i < len && j < len && k < len) begin
        a = seq_elems[(i + k) % len];
        b = seq_elems[(j + k) % len];
        if (a == b) begin
          k++;
        end else begin
          if (a > b) i = i + k + 1;
          else j = j + k + 1;
          if (i == j) j++;
          k = 0;
        end
      end
      return (i < j) ? i : j;
    endfunction

    function void note_beat(in_beat_t b);
      out_beat_t r;
      if (seq_elems.size() < MaxLen) seq_elems.push_back(b.element_value);
      else seq_ovf = 1'b1;
      if (b.last_element) begin
        r.rotation_start = 8'(least_start(seq_elems.size()));
        r.overflowed = seq_ovf;
        pending.push_back(r);
        seq_elems.delete();
        seq_ovf = 1'b0;
      end
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t want;
      if (pending.size() == 0) begin
        report("result with none expected");
        return;
      end
      want = pending.pop_front();
      if (got.rotation_start !== want.rotation_start)
        report($sformatf("rotation_start got %0d want %0d", got.rotation_start,
                         want.rotation_start));
      if (got.overflowed !== want.overflowed)
        report($sformatf("overflowed got %0b want %0b", got.overflowed,
                         want.overflowed));
    endfunction

    function void report(string msg);
      errors++;
      $display("mismatch at %0t: %s", $time, msg);
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start_i = 1'b0;
  in_beat_t  in_i = '0;
  logic      busy_o, done_o;
  out_beat_t res_o;

  rotation_board board = new();
  int        idle_pct = 0;
  int        quiet_cycles = 0;
  localparam int QuietLimit = 20000;

  least_rotation_index uut (.*);

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) board.note_beat(in_i);
      if (done_o) board.check_result(res_o);
      if ((start_i && !busy_o) || done_o) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic send_beat(logic [15:0] v, logic last);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_i <= '{element_value: v, last_element: last};
    @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic send_seq(logic [15:0] vals[$]);
    foreach (vals[n]) send_beat(vals[n], n == vals.size() - 1);
  endtask

  task automatic random_seq(int len, int span);
    logic [15:0] vals[$];
    int period;
    period = $urandom_range(1, 4);
    for (int n = 0; n < len; n++) begin
      if ($urandom_range(3) == 0 && n >= period) vals.push_back(vals[n - period]);
      else if (span == 0) vals.push_back(16'($urandom));
      else vals.push_back(16'($urandom_range(span)));
    end
    send_seq(vals);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int sent, len, span;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_seq('{16'hffff});
    send_seq('{16'h0000});
    send_seq('{16'h0005, 16'h0005, 16'h0005});
    send_seq('{16'hffff, 16'h0000, 16'hffff, 16'h0000});
    send_seq('{16'h0003, 16'h0001, 16'h0002, 16'h0001, 16'h0002});
    send_seq('{16'h8000, 16'h7fff, 16'h0000, 16'hffff});
    drain();
    for (int n = 0; n < 260; n++) send_beat(16'(n * 7919), n == 259);
    for (int n = 0; n < 256; n++) send_beat(16'(255 - n), n == 255);
    drain();
    sent = 0;
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 1) ? 58 : (phase == 3) ? 6 : 0;
      while (sent < (phase + 1) * 215) begin
        len = ($urandom_range(19) == 0) ? $urandom_range(200, 262) : $urandom_range(1, 16);
        span = ($urandom_range(1) == 0) ? $urandom_range(1, 3) : 0;
        random_seq(len, span);
        sent += len;
      end
      drain();
    end
    drain();
    repeat (50) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire
